// ===== hdl/rain_trail_pixel_generator_defines.svh =====
// Assertion macros for the rain trail pixel generator.
// Depends on rtpg_pkg for the pipeline latency; expects clock and reset in scope.
`ifndef RAIN_TRAIL_PIXEL_GENERATOR_DEFINES_SVH
`define RAIN_TRAIL_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RTPG_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication across the full pipeline latency
`define RTPG_ASSERT_LATENCY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##(rtpg_pkg::PIPE_LATENCY) (cons)) else $error(msg);

`endif

// ===== hdl/rtpg_pkg.sv =====
// Shared types, constants and stage functions of the rain trail pixel generator.
// No dependencies.
package rtpg_pkg;

   // Field widths
   localparam int ELAPSED_W = 64;
   localparam int PERIOD_W  = 32;
   localparam int TRAVEL_W  = 10;
   localparam int LEVEL_W   = 8;

   // Pipeline shape
   localparam int TICK_STAGES  = ELAPSED_W;
   localparam int PHASE_STAGES = 32;
   localparam int LEVEL_STAGES = LEVEL_W;
   localparam int HASH_STAGES  = 3;
   localparam int PIPE_LATENCY = 1 + HASH_STAGES + TICK_STAGES + 1 + LEVEL_STAGES + 1;

   // Parameter defaults
   localparam int PANEL_COUNT_DEF  = 4;
   localparam int PANEL_WIDTH_DEF  = 8;
   localparam int PANEL_HEIGHT_DEF = 8;

   // Mixer constants
   localparam logic [31:0] MIX_ADD  = 32'h9e37_79b9;
   localparam logic [31:0] MIX_MUL1 = 32'h7feb_352d;
   localparam logic [31:0] MIX_MUL2 = 32'h846c_a68b;

   // Register indexes
   localparam logic [7:0] REG_STEP_PERIOD = 8'd0;
   localparam logic [7:0] REG_TRAIL_ROWS  = 8'd1;
   localparam logic [7:0] REG_HEAD_LEVEL  = 8'd2;
   localparam logic [7:0] REG_GAP_LENGTH  = 8'd3;

   // Register reset values
   localparam logic [31:0] STEP_PERIOD_RST = 32'd50000;
   localparam logic [7:0]  TRAIL_ROWS_RST  = 8'd6;
   localparam logic [7:0]  HEAD_LEVEL_RST  = 8'd255;
   localparam logic [7:0]  GAP_LENGTH_RST  = 8'd8;

   // Item in the front end (input register and hash)
   typedef struct packed {
      logic                 valid;
      logic                 active;
      logic                 ok;
      logic [2:0]           row;
      logic [1:0]           divisor;
      logic [ELAPSED_W-1:0] elapsed;
      logic [31:0]          mix;
   } item_type;

   // Item in the tick divider
   typedef struct packed {
      logic                 valid;
      logic                 active;
      logic                 ok;
      logic [2:0]           row;
      logic [1:0]           divisor;
      logic [ELAPSED_W-1:0] dividend;
      logic [PERIOD_W-1:0]  rem;
      logic [1:0]           rdiv;
      logic [TRAVEL_W-1:0]  rtrav;
      logic [31:0]          seed;
      logic [TRAVEL_W-1:0]  rphase;
   } tick_stage_type;

   // Item in the level divider
   typedef struct packed {
      logic               valid;
      logic               ok;
      logic               lit;
      logic [LEVEL_W:0]   den;
      logic [LEVEL_W-1:0] num;
      logic [LEVEL_W:0]   rem;
      logic [LEVEL_W-1:0] quo;
   } level_stage_type;

   // Remainder of a 24-bit value by three: base-4 digit sums
   function automatic logic [1:0] mod3_24(input logic [23:0] x);
      logic [5:0] s;
      logic [3:0] r;
      s = '0;
      for (int i = 0; i < 12; i++) s = s + 6'(x[2*i +: 2]);
      r = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
      if (r >= 4'd9) r = r - 4'd9;
      if (r >= 4'd6) r = r - 4'd6;
      if (r >= 4'd3) r = r - 4'd3;
      return r[1:0];
   endfunction

   // One bit of elapsed/period, of tick/divisor, of (tick/divisor) mod travel,
   // and optionally one bit of seed mod travel
   function automatic tick_stage_type tick_step(input tick_stage_type s,
                                                input logic [PERIOD_W-1:0] period,
                                                input logic [TRAVEL_W-1:0] travel,
                                                input logic phase_en);
      tick_stage_type n;
      logic [PERIOD_W:0]   t;
      logic                q;
      logic [2:0]          t2;
      logic                qd;
      logic [TRAVEL_W:0]   t3;
      logic [TRAVEL_W:0]   t4;
      n = s;
      n.dividend = {s.dividend[ELAPSED_W-2:0], 1'b0};
      t = {s.rem, s.dividend[ELAPSED_W-1]};
      if (t >= {1'b0, period}) begin
         q = 1'b1;
         n.rem = PERIOD_W'(t - {1'b0, period});
      end else begin
         q = 1'b0;
         n.rem = t[PERIOD_W-1:0];
      end
      t2 = {s.rdiv, q};
      if (t2 >= {1'b0, s.divisor}) begin
         qd = 1'b1;
         n.rdiv = 2'(t2 - {1'b0, s.divisor});
      end else begin
         qd = 1'b0;
         n.rdiv = t2[1:0];
      end
      t3 = {s.rtrav, qd};
      if (t3 >= {1'b0, travel}) n.rtrav = TRAVEL_W'(t3 - {1'b0, travel});
      else n.rtrav = t3[TRAVEL_W-1:0];
      t4 = {s.rphase, s.seed[31]};
      if (phase_en) begin
         n.seed = {s.seed[30:0], 1'b0};
         if (t4 >= {1'b0, travel}) n.rphase = TRAVEL_W'(t4 - {1'b0, travel});
         else n.rphase = t4[TRAVEL_W-1:0];
      end
      return n;
   endfunction

   // One quotient bit of head_level / (dist + 1)
   function automatic level_stage_type level_step(input level_stage_type s);
      level_stage_type n;
      logic [LEVEL_W+1:0] t;
      logic               q;
      n = s;
      t = {s.rem, s.num[LEVEL_W-1]};
      if (t >= {1'b0, s.den}) begin
         q = 1'b1;
         n.rem = (LEVEL_W+1)'(t - {1'b0, s.den});
      end else begin
         q = 1'b0;
         n.rem = t[LEVEL_W:0];
      end
      n.num = {s.num[LEVEL_W-2:0], 1'b0};
      n.quo = {s.quo[LEVEL_W-2:0], q};
      return n;
   endfunction

endpackage

// ===== hdl/rtpg_hash.sv =====
// Three-stage integer mixer giving each column's seed and speed divisor.
// Depends on rtpg_pkg.
module rtpg_hash (
   input  logic              clock,
   input  logic              reset,
   input  rtpg_pkg::item_type in_item,
   output rtpg_pkg::item_type out_item
);

   rtpg_pkg::item_type h1_ff, h1_in;
   rtpg_pkg::item_type h2_ff, h2_in;
   rtpg_pkg::item_type h3_ff, h3_in;
   logic [31:0] v1;
   logic [31:0] v2;
   logic [31:0] v3;

   // Add, fold, first multiply
   always_comb begin
      v1 = in_item.mix + rtpg_pkg::MIX_ADD;
      v1 = v1 ^ (v1 >> 16);
      h1_in = in_item;
      h1_in.mix = v1 * rtpg_pkg::MIX_MUL1;
   end

   // Fold, second multiply
   always_comb begin
      v2 = h1_ff.mix ^ (h1_ff.mix >> 15);
      h2_in = h1_ff;
      h2_in.mix = v2 * rtpg_pkg::MIX_MUL2;
   end

   // Final fold, speed divisor 1 to 3
   always_comb begin
      v3 = h2_ff.mix ^ (h2_ff.mix >> 16);
      h3_in = h2_ff;
      h3_in.mix = v3;
      h3_in.divisor = 2'd1 + rtpg_pkg::mod3_24(v3[31:8]);
   end

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      h3_ff <= h3_in;
      if (reset) begin
         h1_ff.valid <= 1'b0;
         h2_ff.valid <= 1'b0;
         h3_ff.valid <= 1'b0;
      end
   end

   assign out_item = h3_ff;

endmodule

// ===== hdl/rtpg_tick_div.sv =====
// Bit-per-stage divider: elapsed/period, then /divisor and mod travel on the
// fly, with the seed reduced mod travel alongside. Depends on rtpg_pkg.
module rtpg_tick_div (
   input  logic                                clock,
   input  logic                                reset,
   input  rtpg_pkg::item_type                  in_item,
   input  logic [rtpg_pkg::PERIOD_W-1:0]       period,
   input  logic [rtpg_pkg::TRAVEL_W-1:0]       travel,
   output rtpg_pkg::tick_stage_type            out_stage
);

   rtpg_pkg::tick_stage_type st0;
   rtpg_pkg::tick_stage_type st_ff [1:rtpg_pkg::TICK_STAGES];

   // Load the divider front
   always_comb begin
      st0.valid    = in_item.valid;
      st0.active   = in_item.active;
      st0.ok       = in_item.ok;
      st0.row      = in_item.row;
      st0.divisor  = in_item.divisor;
      st0.dividend = in_item.elapsed;
      st0.rem      = '0;
      st0.rdiv     = '0;
      st0.rtrav    = '0;
      st0.seed     = in_item.mix;
      st0.rphase   = '0;
   end

   // Advance one quotient bit per stage
   for (genvar i = 1; i <= rtpg_pkg::TICK_STAGES; i++) begin : g_stage
      rtpg_pkg::tick_stage_type prev;
      if (i == 1) begin : g_first
         assign prev = st0;
      end else begin : g_rest
         assign prev = st_ff[i-1];
      end
      always_ff @(posedge clock) begin
         st_ff[i] <= rtpg_pkg::tick_step(prev, period, travel,
                                         (i <= rtpg_pkg::PHASE_STAGES));
         if (reset) st_ff[i].valid <= 1'b0;
      end
   end

   assign out_stage = st_ff[rtpg_pkg::TICK_STAGES];

endmodule

// ===== hdl/rtpg_level.sv =====
// Head position, trail test and the green level divider with output register.
// Depends on rtpg_pkg.
module rtpg_level (
   input  logic                               clock,
   input  logic                               reset,
   input  rtpg_pkg::tick_stage_type           in_stage,
   input  logic [rtpg_pkg::TRAVEL_W-1:0]      travel,
   input  logic [7:0]                         trail_rows,
   input  logic [rtpg_pkg::LEVEL_W-1:0]       head_level,
   output logic                               out_valid,
   output logic [rtpg_pkg::LEVEL_W-1:0]       out_green,
   output logic                               out_lit,
   output logic                               out_ok
);

   localparam int N = rtpg_pkg::LEVEL_STAGES;

   logic [rtpg_pkg::TRAVEL_W:0]   sum;
   logic [rtpg_pkg::TRAVEL_W-1:0] head;
   logic [rtpg_pkg::TRAVEL_W:0]   diff;
   logic                          on_trail;
   rtpg_pkg::level_stage_type     l0_in;
   rtpg_pkg::level_stage_type     lv_ff [0:N];
   logic                          valid_ff;
   logic [rtpg_pkg::LEVEL_W-1:0]  green_ff, green_in;
   logic                          lit_ff;
   logic                          ok_ff;

   // Head row and distance behind it
   always_comb begin
      sum  = {1'b0, in_stage.rtrav} + {1'b0, in_stage.rphase};
      if (sum >= {1'b0, travel}) head = rtpg_pkg::TRAVEL_W'(sum - {1'b0, travel});
      else head = sum[rtpg_pkg::TRAVEL_W-1:0];
      diff = {1'b0, head} - {8'd0, in_stage.row};
      on_trail = in_stage.active && (head >= {7'd0, in_stage.row})
                 && (diff[rtpg_pkg::TRAVEL_W-1:0] <= {2'd0, trail_rows});
      l0_in.valid = in_stage.valid;
      l0_in.ok    = in_stage.ok;
      l0_in.lit   = on_trail;
      l0_in.den   = {1'b0, diff[rtpg_pkg::LEVEL_W-1:0]} + 9'd1;
      l0_in.num   = head_level;
      l0_in.rem   = '0;
      l0_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      lv_ff[0] <= l0_in;
      if (reset) lv_ff[0].valid <= 1'b0;
   end

   // Restoring division, one quotient bit per stage
   for (genvar j = 1; j <= N; j++) begin : g_div
      always_ff @(posedge clock) begin
         lv_ff[j] <= rtpg_pkg::level_step(lv_ff[j-1]);
         if (reset) lv_ff[j].valid <= 1'b0;
      end
   end

   // Floor lit pixels at one, drop unlit ones to dark
   always_comb begin
      if (!lv_ff[N].lit) green_in = '0;
      else if (lv_ff[N].quo == '0) green_in = rtpg_pkg::LEVEL_W'(1);
      else green_in = lv_ff[N].quo;
   end

   always_ff @(posedge clock) begin
      green_ff <= green_in;
      lit_ff   <= lv_ff[N].lit;
      ok_ff    <= lv_ff[N].ok;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= lv_ff[N].valid;
   end

   assign out_valid = valid_ff;
   assign out_green = green_ff;
   assign out_lit   = lit_ff;
   assign out_ok    = ok_ff;

endmodule

// ===== hdl/rain_trail_pixel_generator.sv =====
// Top level of the rain trail pixel generator: registers, input stage, pipeline.
// Depends on rtpg_pkg, rtpg_hash, rtpg_tick_div, rtpg_level and the defines header.
//
//   channel   ports                          handshake
//   request   start, busy, req_*             start && !busy
//   result    rsp_valid, rsp_*               rsp_valid, one cycle
//   config    csr_valid, csr_ready, csr_*    csr_valid && csr_ready
//
// One pixel enters every cycle; busy never rises. Each result passes through the
// input register, the hash, the 64-stage tick divider, the level divider and the
// output register in that order.
// Synchronous reset clears valid bits and restores the register defaults.
// The receiver cannot stall, so the pipeline always advances.
`include "rain_trail_pixel_generator_defines.svh"

module rain_trail_pixel_generator #(
   parameter int PANEL_COUNT  = rtpg_pkg::PANEL_COUNT_DEF,
   parameter int PANEL_WIDTH  = rtpg_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = rtpg_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [7:0]                           req_panel_index,
   input  logic [2:0]                           req_column,
   input  logic [2:0]                           req_row,
   input  logic [rtpg_pkg::ELAPSED_W-1:0]       req_elapsed_time_us,
   output logic                                 rsp_valid,
   output logic [rtpg_pkg::LEVEL_W-1:0]         rsp_green_level,
   output logic                                 rsp_pixel_lit,
   output logic                                 rsp_panel_ok,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [7:0]                           csr_index,
   input  logic [31:0]                          csr_data
);

   localparam logic [8:0] PANEL_LIMIT  = 9'(PANEL_COUNT);
   localparam logic [6:0] WIDTH_LIMIT  = 7'(PANEL_WIDTH);
   localparam logic [6:0] HEIGHT_LIMIT = 7'(PANEL_HEIGHT);

   logic [31:0] step_period_ff;
   logic [7:0]  trail_rows_ff;
   logic [7:0]  head_level_ff;
   logic [7:0]  gap_length_ff;
   logic [rtpg_pkg::PERIOD_W-1:0] period;
   logic [rtpg_pkg::TRAVEL_W-1:0] travel;
   logic        panel_ok;
   rtpg_pkg::item_type       in_ff, in_in;
   rtpg_pkg::item_type       hash_out;
   rtpg_pkg::tick_stage_type tick_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff <= rtpg_pkg::STEP_PERIOD_RST;
         trail_rows_ff  <= rtpg_pkg::TRAIL_ROWS_RST;
         head_level_ff  <= rtpg_pkg::HEAD_LEVEL_RST;
         gap_length_ff  <= rtpg_pkg::GAP_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rtpg_pkg::REG_STEP_PERIOD: step_period_ff <= csr_data;
            rtpg_pkg::REG_TRAIL_ROWS:  trail_rows_ff  <= csr_data[7:0];
            rtpg_pkg::REG_HEAD_LEVEL:  head_level_ff  <= csr_data[7:0];
            rtpg_pkg::REG_GAP_LENGTH:  gap_length_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Derived settings; the user must keep them stable while items are in flight, the block does not enforce it
   assign period = (step_period_ff == '0) ? rtpg_pkg::PERIOD_W'(1) : step_period_ff;
   assign travel = rtpg_pkg::TRAVEL_W'(PANEL_HEIGHT) + {2'd0, trail_rows_ff}
                   + {2'd0, gap_length_ff};

   // Capture the request beat
   always_comb begin
      panel_ok       = {1'b0, req_panel_index} < PANEL_LIMIT;
      in_in.valid    = start && !busy;
      in_in.ok       = panel_ok;
      in_in.active   = panel_ok && ({4'd0, req_column} < WIDTH_LIMIT)
                       && ({4'd0, req_row} < HEIGHT_LIMIT);
      in_in.row      = req_row;
      in_in.divisor  = 2'd1;
      in_in.elapsed  = req_elapsed_time_us;
      in_in.mix      = {21'd0, req_panel_index, req_column};
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (reset) in_ff.valid <= 1'b0;
   end

   rtpg_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .in_item  (in_ff),
      .out_item (hash_out)
   );

   rtpg_tick_div u_tick_div (
      .clock     (clock),
      .reset     (reset),
      .in_item   (hash_out),
      .period    (period),
      .travel    (travel),
      .out_stage (tick_out)
   );

   rtpg_level u_level (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (tick_out),
      .travel     (travel),
      .trail_rows (trail_rows_ff),
      .head_level (head_level_ff),
      .out_valid  (rsp_valid),
      .out_green  (rsp_green_level),
      .out_lit    (rsp_pixel_lit),
      .out_ok     (rsp_panel_ok)
   );

   // Checks
   `RTPG_ASSERT_LATENCY(a_latency, start && !busy, rsp_valid, "result beat missing")
   `RTPG_ASSERT_IMPLIES(a_bad_panel, rsp_valid && !rsp_panel_ok,
      !rsp_pixel_lit && (rsp_green_level == '0), "bad panel lit")
   `RTPG_ASSERT_IMPLIES(a_lit_level, rsp_valid,
      rsp_pixel_lit == (rsp_green_level != '0), "lit flag and level disagree")

endmodule
